// File: src/necir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, constants and timing-window helper for the NEC pulse decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

	// Decoded word length
	localparam int DATA_BITS_DEF = 32;

	// Field and datapath widths
	localparam int TICKS_W  = 15;
	localparam int RATE_W   = 8;
	localparam int MARGIN_W = 10;
	localparam int STATUS_W = 3;
	localparam int CODE_W   = 32;
	localparam int IDX_W    = 6;
	localparam int NUM_W    = 19;              // ticks*10 fits in 19 bits
	localparam int US_W     = NUM_W;           // quotient width
	localparam int TGT_W    = 14;
	localparam int SUM_W    = US_W + 1;
	localparam int DIV_STEPS = NUM_W;          // one quotient bit per cycle
	localparam int CNT_W    = $clog2(DIV_STEPS);

	// Pulse targets in microseconds
	localparam logic [TGT_W-1:0] HDR_MARK_US   = TGT_W'(9000);
	localparam logic [TGT_W-1:0] HDR_SPACE_US  = TGT_W'(4500);
	localparam logic [TGT_W-1:0] BIT_MARK_US   = TGT_W'(560);
	localparam logic [TGT_W-1:0] ONE_SPACE_US  = TGT_W'(1690);
	localparam logic [TGT_W-1:0] ZERO_SPACE_US = TGT_W'(560);
	localparam logic [TGT_W-1:0] END_MARK_US   = TGT_W'(560);
	localparam logic [TGT_W-1:0] END_SPACE_US  = TGT_W'(0);

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_SHORT  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_HEADER = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_BIT    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_END    = 3'd4;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TICKS  = 2'd0,
		REG_MARGIN = 2'd1,
		REG_LEVEL  = 2'd2
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [RATE_W-1:0]   TICKS_RST  = 8'd8;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd60;
	localparam logic                LEVEL_RST  = 1'b0;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture item, start both divisions
		logic step;      // one division step
		logic update;    // commit decode state, emit result on last item
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;      // captured item closes the capture
	} dp_stat_t;

	// Strict window: tgt - m < us < tgt + m, kept unsigned
	function automatic logic near_us(input logic [US_W-1:0] us,
			input logic [MARGIN_W-1:0] m, input logic [TGT_W-1:0] tgt);
		logic [SUM_W-1:0] lo_sum;
		logic [SUM_W-1:0] hi_sum;
		lo_sum = SUM_W'(us) + SUM_W'(m);
		hi_sum = SUM_W'(tgt) + SUM_W'(m);
		return (lo_sum > SUM_W'(tgt)) && (SUM_W'(us) < hi_sum);
	endfunction

endpackage

// File: src/nec_ir_pulse_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder
// NEC infrared frame decoder fed with received pulse items, APB configured.
// ----------------------------------------------------------------------------
// Result: after the last item of a capture is accepted, the dividers step
//   and a commit state registers the result, held while a prior one stalls.
// Items: one is taken only after the last is committed; the bit-serial
//   tick-to-us dividers give one quotient bit per cycle, both in parallel.
// Reset: arst_n clears the sequencer, decode state and result valid at once;
//   configuration returns to 8 ticks per 10 us, 60 us margin, active low.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder #(
	parameter int DATA_BITS = necir_pkg::DATA_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           first_level,
	input  logic [necir_pkg::TICKS_W-1:0]  first_ticks,
	input  logic                           second_level,
	input  logic [necir_pkg::TICKS_W-1:0]  second_ticks,
	input  logic                           last_item,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [necir_pkg::STATUS_W-1:0] status,
	output logic [necir_pkg::CODE_W-1:0]   code,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import necir_pkg::*;

	logic [RATE_W-1:0]   ticks_q;
	logic [MARGIN_W-1:0] margin_q;
	logic                level_q;
	logic                cfg_wr;
	reg_idx_t            reg_sel;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Registers sit on word addresses; the low two address bits are ignored
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= TICKS_RST;
			margin_q <= MARGIN_RST;
			level_q  <= LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_TICKS:  ticks_q  <= pwdata[RATE_W-1:0];
				REG_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
				REG_LEVEL:  level_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back; unmapped addresses read as zero
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_TICKS:  prdata = 32'(ticks_q);
			REG_MARGIN: prdata = 32'(margin_q);
			REG_LEVEL:  prdata = 32'(level_q);
			default:    prdata = '0;
		endcase
	end

	// Sequencer: accept in idle, divide, then commit the item
	necir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Conversion, window checks, shift word and result registers
	necir_dpath #(
		.DATA_BITS (DATA_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.first_level      (first_level),
		.first_ticks      (first_ticks),
		.second_level     (second_level),
		.second_ticks     (second_ticks),
		.last_item        (last_item),
		.ticks_per_ten_us (ticks_q),
		.margin_us        (margin_q),
		.active_level     (level_q),
		.status           (status),
		.code             (code)
	);

	// An accepted item keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting an item");

	// A failed or short capture never carries a code
	a_code_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> code == '0)
		else $error("nonzero code with error status");

	// Only defined status codes leave the block
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK) || (status == STAT_SHORT) ||
			(status == STAT_HEADER) || (status == STAT_BIT) || (status == STAT_END))
		else $error("undefined status code");

	// A new result only follows an item being processed
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in flight");

endmodule

// File: src/necir_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_div
// Restoring divider, one quotient bit per step, numerator register reused
// for the quotient.
// ----------------------------------------------------------------------------
module necir_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [necir_pkg::NUM_W-1:0] numer,
	input  logic [necir_pkg::RATE_W-1:0] divisor,
	output logic [necir_pkg::US_W-1:0]  quot
);
	import necir_pkg::*;

	logic [NUM_W-1:0]  n_q;
	logic [RATE_W-1:0] r_q;
	logic [RATE_W:0]   r_sh;
	logic [RATE_W:0]   diff;
	logic              ge;

	assign r_sh = {r_q, n_q[NUM_W-1]};
	assign diff = r_sh - {1'b0, divisor};
	assign ge   = (r_sh >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (load) begin
			n_q <= numer;
			r_q <= '0;
		end else if (step) begin
			r_q <= ge ? diff[RATE_W-1:0] : r_sh[RATE_W-1:0];
			n_q <= {n_q[NUM_W-2:0], ge};
		end
	end

	assign quot = n_q;

endmodule

// File: src/necir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_ctrl
// Sequencer: accept an item, run the division steps, commit, emit result.
// ----------------------------------------------------------------------------
module necir_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  necir_pkg::dp_stat_t   stat,
	output necir_pkg::ctrl_cmd_t  cmd
);
	import necir_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t           state_q;
	state_t           state_n;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             blocked;

	assign accept  = in_valid && (state_q == S_IDLE);
	// Hold the commit of a last item while an earlier result still waits
	assign blocked = stat.last && out_valid && out_stall;

	assign in_stall   = (state_q != S_IDLE);
	assign cmd.load   = accept;
	assign cmd.step   = (state_q == S_DIV);
	assign cmd.update = (state_q == S_UPD) && !blocked;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_n = S_DIV;
			S_DIV:  if (cnt_q == '0) state_n = S_UPD;
			S_UPD:  if (!blocked) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.update && stat.last) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// File: src/necir_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_dpath
// Item capture, tick-to-microsecond conversion, pulse checks, decode state
// and result registers.
// ----------------------------------------------------------------------------
module necir_dpath #(
	parameter int DATA_BITS = necir_pkg::DATA_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  necir_pkg::ctrl_cmd_t           cmd,
	output necir_pkg::dp_stat_t            stat,
	input  logic                           first_level,
	input  logic [necir_pkg::TICKS_W-1:0]  first_ticks,
	input  logic                           second_level,
	input  logic [necir_pkg::TICKS_W-1:0]  second_ticks,
	input  logic                           last_item,
	input  logic [necir_pkg::RATE_W-1:0]   ticks_per_ten_us,
	input  logic [necir_pkg::MARGIN_W-1:0] margin_us,
	input  logic                           active_level,
	output logic [necir_pkg::STATUS_W-1:0] status,
	output logic [necir_pkg::CODE_W-1:0]   code
);
	import necir_pkg::*;

	localparam logic [IDX_W-1:0] ITEM_TOTAL = IDX_W'(DATA_BITS + 2);
	localparam logic [IDX_W-1:0] BIT_LAST   = IDX_W'(DATA_BITS);
	localparam logic [IDX_W-1:0] IDX_MAX    = '1;

	logic                 fl_q;
	logic                 sl_q;
	logic                 last_q;
	logic [IDX_W-1:0]     idx_q;
	logic [DATA_BITS-1:0] shift_q;
	logic [STATUS_W-1:0]  err_q;

	logic [RATE_W-1:0]    divisor;
	logic [NUM_W-1:0]     numer_a;
	logic [NUM_W-1:0]     numer_b;
	logic [US_W-1:0]      mark_us;
	logic [US_W-1:0]      space_us;

	logic                 lvl_ok;
	logic                 hdr_ok;
	logic                 one_ok;
	logic                 zero_ok;
	logic                 end_ok;
	logic [IDX_W-1:0]     idx_n;
	logic [DATA_BITS-1:0] shift_n;
	logic [STATUS_W-1:0]  err_n;
	logic [STATUS_W-1:0]  res_status;

	// A zero rate divides by one
	assign divisor = (ticks_per_ten_us == '0) ? RATE_W'(1) : ticks_per_ten_us;
	assign numer_a = NUM_W'({first_ticks, 3'b000}) + NUM_W'({first_ticks, 1'b0});
	assign numer_b = NUM_W'({second_ticks, 3'b000}) + NUM_W'({second_ticks, 1'b0});

	necir_div u_div_mark (
		.clk     (clk),
		.load    (cmd.load),
		.step    (cmd.step),
		.numer   (numer_a),
		.divisor (divisor),
		.quot    (mark_us)
	);

	necir_div u_div_space (
		.clk     (clk),
		.load    (cmd.load),
		.step    (cmd.step),
		.numer   (numer_b),
		.divisor (divisor),
		.quot    (space_us)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fl_q   <= first_level;
			sl_q   <= second_level;
			last_q <= last_item;
		end
	end

	assign stat.last = last_q;

	assign lvl_ok  = (fl_q == active_level) && (sl_q != active_level);
	assign hdr_ok  = lvl_ok && near_us(mark_us, margin_us, HDR_MARK_US)
		&& near_us(space_us, margin_us, HDR_SPACE_US);
	assign one_ok  = lvl_ok && near_us(mark_us, margin_us, BIT_MARK_US)
		&& near_us(space_us, margin_us, ONE_SPACE_US);
	assign zero_ok = lvl_ok && near_us(mark_us, margin_us, BIT_MARK_US)
		&& near_us(space_us, margin_us, ZERO_SPACE_US);
	assign end_ok  = lvl_ok && near_us(mark_us, margin_us, END_MARK_US)
		&& near_us(space_us, margin_us, END_SPACE_US);

	always_comb begin
		err_n   = err_q;
		shift_n = shift_q;
		if ((err_q == STAT_OK) && (idx_q < ITEM_TOTAL)) begin
			if (idx_q == '0) begin
				if (!hdr_ok) err_n = STAT_HEADER;
			end else if (idx_q <= BIT_LAST) begin
				// one is tested first when both windows match
				if (one_ok) begin
					shift_n = {shift_q[DATA_BITS-2:0], 1'b1};
				end else if (zero_ok) begin
					shift_n = {shift_q[DATA_BITS-2:0], 1'b0};
				end else begin
					err_n = STAT_BIT;
				end
			end else begin
				if (!end_ok) err_n = STAT_END;
			end
		end
		idx_n = (idx_q != IDX_MAX) ? idx_q + 1'b1 : idx_q;
		if (idx_n < ITEM_TOTAL) begin
			res_status = STAT_SHORT;
		end else begin
			res_status = err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			shift_q <= '0;
			err_q   <= STAT_OK;
		end else if (cmd.update) begin
			if (last_q) begin
				idx_q   <= '0;
				shift_q <= '0;
				err_q   <= STAT_OK;
			end else begin
				idx_q   <= idx_n;
				shift_q <= shift_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && last_q) begin
			status <= res_status;
			code   <= (res_status == STAT_OK) ? CODE_W'(shift_n) : '0;
		end
	end

endmodule
